// ===== src/rqmr_pkg.sv =====
package rqmr_pkg;

    localparam int FUNC_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int SLOT_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int S_PAD_W   = S_TDATA_W - VALUE_W - SLOT_W;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - OCC_W;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOSLOT = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  removed_value;
        logic [OCC_W-1:0]    occupancy;
    } result_t;

endpackage

// ===== src/ring_queue_with_middle_removal.sv =====
// Ordered ring queue of entry handles with push, pop and removal at a slot.
//
// Input channel s_*: one beat is one operation. s_tuser carries func
// (push, pop, remove at slot); s_tdata carries entry_value and slot.
// Result channel m_*: exactly one beat per operation, in order, with the
// status, the removed handle and the occupancy after the operation.
//
// m_tvalid rises after the accepting edge once the sequencer has passed
// through CHECK and EMIT for push, for func 3 and for any error; a pop or
// removal at the head adds a read of the ring in RDV; a removal in the
// middle adds n SHIFT steps, where n is the number of entries that move one
// slot (at most DEPTH - 2), one per cycle through the single read and single
// write port of the ring memory. s_tready returns high in the cycle the
// result is loaded into the output register. One operation is in flight at a
// time; a result waiting on m_tready still frees the sequencer, and the
// next result then holds it until the output register frees up.
//
// Reset empties the queue and sets the head to slot 0; ring contents are
// not cleared and need no clearing pass.
module ring_queue_with_middle_removal #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_value [31:0], slot [35:32], zero [39:36]
    input  logic [rqmr_pkg::S_TDATA_W-1:0]   s_tdata,
    // func [1:0]
    input  logic [rqmr_pkg::FUNC_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // removed_value [31:0], occupancy [36:32], zero [39:37]
    output logic [rqmr_pkg::M_TDATA_W-1:0]   m_tdata,
    // status [1:0]
    output logic [rqmr_pkg::STATUS_W-1:0]    m_tuser
);

    import rqmr_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic                   res_valid;
    logic                   res_ready;
    result_t                res;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [ENTRY_WIDTH-1:0] mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;
    logic [ENTRY_WIDTH-1:0] mem_rdata;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    rqmr_seq #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .IDX_W       (IDX_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_value  (s_tdata[VALUE_W-1:0]),
        .in_slot   (s_tdata[VALUE_W+SLOT_W-1:VALUE_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    rqmr_ram #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .IDX_W       (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_res_reg.occupancy, m_res_reg.removed_value};

endmodule

// ===== src/rqmr_ram.sv =====
module rqmr_ram #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32,
    parameter int IDX_W       = $clog2(DEPTH)
) (
    input  logic                   aclk,
    input  logic                   we,
    input  logic [IDX_W-1:0]       waddr,
    input  logic [ENTRY_WIDTH-1:0] wdata,
    input  logic [IDX_W-1:0]       raddr,
    output logic [ENTRY_WIDTH-1:0] rdata
);

    logic [ENTRY_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/rqmr_seq.sv =====
module rqmr_seq #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32,
    parameter int IDX_W       = $clog2(DEPTH)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rqmr_pkg::FUNC_W-1:0]     in_func,
    input  logic [rqmr_pkg::VALUE_W-1:0]    in_value,
    input  logic [rqmr_pkg::SLOT_W-1:0]     in_slot,
    output logic                            res_valid,
    input  logic                            res_ready,
    output rqmr_pkg::result_t               res,
    output logic                            mem_we,
    output logic [IDX_W-1:0]                mem_waddr,
    output logic [ENTRY_WIDTH-1:0]          mem_wdata,
    output logic [IDX_W-1:0]                mem_raddr,
    input  logic [ENTRY_WIDTH-1:0]          mem_rdata
);

    import rqmr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

    typedef enum logic [2:0] {IDLE, CHECK, RDV, SHIFT, EMIT} state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [ENTRY_WIDTH-1:0] value_reg, value_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [ENTRY_WIDTH-1:0] removed_reg, removed_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [IDX_W-1:0]       src_reg, src_next;
    logic [IDX_W-1:0]       dst_reg, dst_next;
    logic [IDX_W-1:0]       left_reg, left_next;
    logic                   up_reg, up_next;
    logic                   adv_reg, adv_next;
    logic                   inc_reg, inc_next;
    logic                   dec_reg, dec_next;

    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] tail;
    logic             full;
    logic             empty;
    logic             wrapped;
    logic             slot_bad;
    logic [IDX_W-1:0] pos;
    logic [SUM_W-1:0] off;
    logic             head_mode;
    logic             up_mode;
    logic [SUM_W-1:0] moves;
    logic [CNT_W-1:0] count_after;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] step_idx(input logic up, input logic [IDX_W-1:0] i);
        return up ? prev_idx(i) : next_idx(i);
    endfunction

    always_comb begin
        sum       = SUM_W'(head_reg) + SUM_W'(count_reg);
        tail      = (sum >= SUM_W'(DEPTH)) ? IDX_W'(sum - SUM_W'(DEPTH)) : IDX_W'(sum);
        full      = (count_reg == CNT_W'(DEPTH));
        empty     = (count_reg == '0);
        wrapped   = (sum > SUM_W'(DEPTH));
        slot_bad  = (CMP_W'(slot_reg) >= CMP_W'(DEPTH));
        pos       = (func_reg == FUNC_REMOVE) ? IDX_W'(slot_reg) : head_reg;
        off       = (pos >= head_reg) ? SUM_W'(pos) - SUM_W'(head_reg)
                                      : SUM_W'(pos) + SUM_W'(DEPTH) - SUM_W'(head_reg);
        head_mode = (pos == head_reg);
        up_mode   = !head_mode && wrapped && (pos > head_reg);
        if (head_mode) begin
            moves = '0;
        end else if (up_mode) begin
            moves = off;
        end else begin
            moves = SUM_W'(count_reg) - 1'b1 - off;
        end
        if (inc_reg) begin
            count_after = count_reg + 1'b1;
        end else if (dec_reg) begin
            count_after = count_reg - 1'b1;
        end else begin
            count_after = count_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        func_next    = func_reg;
        value_next   = value_reg;
        slot_next    = slot_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        pos_next     = pos_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        left_next    = left_reg;
        up_next      = up_reg;
        adv_next     = adv_reg;
        inc_next     = inc_reg;
        dec_next     = dec_reg;
        mem_we       = 1'b0;
        mem_waddr    = dst_reg;
        mem_wdata    = mem_rdata;
        mem_raddr    = src_reg;
        in_ready     = (state_reg == IDLE);
        res_valid    = (state_reg == EMIT);

        case (state_reg)
            IDLE: begin
                if (in_valid) begin
                    func_next  = in_func;
                    value_next = ENTRY_WIDTH'(in_value);
                    slot_next  = in_slot;
                    state_next = CHECK;
                end
            end
            CHECK: begin
                removed_next = '0;
                status_next  = ST_OK;
                inc_next     = 1'b0;
                dec_next     = 1'b0;
                adv_next     = 1'b0;
                state_next   = EMIT;
                case (func_reg)
                    FUNC_PUSH: begin
                        if (full) begin
                            status_next = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = tail;
                            mem_wdata = value_reg;
                            inc_next  = 1'b1;
                        end
                    end
                    FUNC_POP, FUNC_REMOVE: begin
                        if (empty) begin
                            status_next = ST_EMPTY;
                        end else if (func_reg == FUNC_REMOVE &&
                                     (slot_bad || off >= SUM_W'(count_reg))) begin
                            status_next = ST_NOSLOT;
                        end else begin
                            mem_raddr  = pos;
                            pos_next   = pos;
                            dec_next   = 1'b1;
                            adv_next   = head_mode || up_mode;
                            up_next    = up_mode;
                            left_next  = IDX_W'(moves);
                            state_next = RDV;
                        end
                    end
                    default: ;
                endcase
            end
            RDV: begin
                removed_next = mem_rdata;
                if (left_reg == '0) begin
                    state_next = EMIT;
                end else begin
                    mem_raddr  = step_idx(up_reg, pos_reg);
                    src_next   = step_idx(up_reg, pos_reg);
                    dst_next   = pos_reg;
                    left_next  = left_reg - 1'b1;
                    state_next = SHIFT;
                end
            end
            SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = dst_reg;
                mem_wdata = mem_rdata;
                dst_next  = src_reg;
                if (left_reg != '0) begin
                    mem_raddr = step_idx(up_reg, src_reg);
                    src_next  = step_idx(up_reg, src_reg);
                    left_next = left_reg - 1'b1;
                end else begin
                    state_next = EMIT;
                end
            end
            EMIT: begin
                if (res_ready) begin
                    count_next = count_after;
                    head_next  = adv_reg ? next_idx(head_reg) : head_reg;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_comb begin
        res.status        = status_reg;
        res.removed_value = VALUE_W'(removed_reg);
        res.occupancy     = OCC_W'(count_after);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
        func_reg    <= func_next;
        value_reg   <= value_next;
        slot_reg    <= slot_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        pos_reg     <= pos_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        left_reg    <= left_next;
        up_reg      <= up_next;
        adv_reg     <= adv_next;
        inc_reg     <= inc_next;
        dec_reg     <= dec_next;
    end

endmodule

// ===== src/rqmr_check.sv =====
module rqmr_check #(
    parameter int DEPTH = 16
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rqmr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rqmr_pkg::STATUS_W-1:0]  m_tuser
);

    import rqmr_pkg::*;

    logic [OCC_W-1:0]   occ;
    logic [VALUE_W-1:0] removed;

    assign occ     = m_tdata[VALUE_W+OCC_W-1:VALUE_W];
    assign removed = m_tdata[VALUE_W-1:0];

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> occ == OCC_W'(DEPTH) && removed == '0)
        else $error("full status with wrong occupancy or value");

    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_EMPTY |-> occ == '0 && removed == '0)
        else $error("empty status with entries or value");

    a_noslot_val: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_NOSLOT |-> removed == '0 && occ != '0)
        else $error("slot error with value or empty queue");

endmodule

bind ring_queue_with_middle_removal rqmr_check #(.DEPTH(DEPTH)) u_rqmr_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
